/* rtl/eash_pkg.sv */
// shared types, constants and helper functions for the eight-accumulator string hash
// no dependencies; used by eash_update and eight_accumulator_string_hash

package eash_pkg;

  localparam logic [7:0] XorOffset  = 8'h0a;
  localparam logic [7:0] SumMask    = 8'h7e;
  localparam logic [7:0] PolyMask   = 8'h4e;
  localparam logic [2:0] ModSixLast = 3'd5;

  typedef struct packed {
    logic [7:0] xor_acc;
    logic [7:0] masked_sum;
    logic [7:0] neg_sum;
    logic [7:0] rotl_acc;
    logic [7:0] rotr_acc;
    logic [7:0] poly_acc;
    logic [7:0] mix_acc;
    logic [7:0] final_mix;
    logic [7:0] position;
    logic [2:0] position_mod_six;
  } eash_state_t;

  localparam eash_state_t StateReset = '{
    xor_acc:          8'd0,
    masked_sum:       8'd0,
    neg_sum:          8'd0,
    rotl_acc:         8'd0,
    rotr_acc:         8'd0,
    poly_acc:         8'd1,
    mix_acc:          8'd0,
    final_mix:        8'd0,
    position:         8'd0,
    position_mod_six: 3'd0
  };

  // low byte of a 32-bit left rotation of a 7-bit code
  function automatic logic [7:0] rotl_low(input logic [6:0] v, input logic [4:0] s);
    logic [31:0] w;
    logic [63:0] d;
    w = {25'd0, v};
    d = {w, w} << s;
    return d[39:32];
  endfunction

  // low byte of a 32-bit right rotation of a 7-bit code
  function automatic logic [7:0] rotr_low(input logic [6:0] v, input logic [4:0] s);
    logic [31:0] w;
    logic [63:0] d;
    w = {25'd0, v};
    d = {w, w} >> s;
    return d[7:0];
  endfunction

endpackage

/* rtl/eash_update.sv */
// next-state logic: applies one character to the eight accumulators and the counters
// depends on eash_pkg

module eash_update (
  input  eash_pkg::eash_state_t cur,
  input  logic [6:0]            character,
  output eash_pkg::eash_state_t nxt
);

  logic [7:0]  c8;
  logic [15:0] c_sq;
  logic [15:0] rot_prod;
  logic [15:0] nm_prod;
  logic [7:0]  poly_term;

  assign c8 = {1'b0, character};

  always_comb begin
    nxt = cur;
    nxt.xor_acc    = cur.xor_acc ^ (c8 + eash_pkg::XorOffset);
    nxt.masked_sum = cur.masked_sum + (c8 & eash_pkg::SumMask);
    nxt.neg_sum    = cur.neg_sum - c8;
    nxt.rotl_acc   = cur.rotl_acc + eash_pkg::rotl_low(character, cur.position[4:0]);
    nxt.rotr_acc   = cur.rotr_acc + eash_pkg::rotr_low(character, cur.position[4:0]);

    c_sq      = {8'd0, c8} * {8'd0, c8};
    poly_term = c_sq[7:0] + c8 + c8 + c8 - cur.position;
    nxt.poly_acc = cur.poly_acc + poly_term;

    // later terms use the values just updated
    rot_prod    = {8'd0, nxt.rotl_acc} * {8'd0, nxt.rotr_acc};
    nxt.mix_acc = cur.mix_acc + c8 + (nxt.masked_sum ^ nxt.xor_acc) + rot_prod[7:0];

    nm_prod       = {8'd0, nxt.neg_sum} * {8'd0, nxt.masked_sum};
    nxt.final_mix = cur.final_mix + nm_prod[7:0] + {nxt.mix_acc[6:0], 1'b0}
                  + {5'd0, cur.position_mod_six} + (nxt.poly_acc & eash_pkg::PolyMask);

    nxt.position         = cur.position + 8'd1;
    nxt.position_mod_six = (cur.position_mod_six >= eash_pkg::ModSixLast) ? 3'd0
                         : cur.position_mod_six + 3'd1;
  end

endmodule

/* rtl/eight_accumulator_string_hash.sv */
// top level of the eight-accumulator string hash: input register, accumulator state,
// output register; depends on eash_pkg and eash_update
// order: an accepted character is held in the input register and updates the state when it
// advances; on a last character the state restarts and the hash word enters the output register at that edge
// throughput: one character per cycle; the 8-bit multiply-add chain in eash_update
// sets the clock period; stalls only when a hash word waits on m_tready and another last arrives
// reset: rst clears the state to its initial values and empties both registers

module eight_accumulator_string_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] character, [7] zero
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // rotr_acc, poly_acc, masked_sum, rotl_acc,
                                 // mix_acc, xor_acc, final_mix, neg_sum (low to high)
);

  logic                  in_valid;
  logic [6:0]            in_char;
  logic                  in_last;
  logic                  advance;
  eash_pkg::eash_state_t state;
  eash_pkg::eash_state_t state_next;

  eash_update u_update (
    .cur       (state),
    .character (in_char),
    .nxt       (state_next)
  );

  // a non-last character produces no word, so only a last one waits on the output
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready) begin
      in_char <= s_tdata[6:0];
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eash_pkg::StateReset;
    end else if (advance) begin
      state <= in_last ? eash_pkg::StateReset : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      m_tdata <= {state_next.neg_sum, state_next.final_mix, state_next.xor_acc,
                  state_next.mix_acc, state_next.rotl_acc, state_next.masked_sum,
                  state_next.poly_acc, state_next.rotr_acc};
    end
  end

  a_mod_six_range: assert property (@(posedge clk) disable iff (rst)
    state.position_mod_six <= eash_pkg::ModSixLast)
    else $error("position_mod_six out of range");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (state == eash_pkg::StateReset && m_tvalid))
    else $error("state not restarted after last character");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid))
    else $error("registers not empty after reset");

endmodule
